FILE: rtl/ssc_pkg.sv
// Shared constants, types and the sine/cosine table for the scan point converter.
// Used by every module of the block; depends on nothing.
package ssc_pkg;

    localparam int ANGLE_STEPS_PER_PI = 180;
    localparam int TRIG_FRAC_BITS     = 15;
    localparam int TWO_PI_STEPS       = 2 * ANGLE_STEPS_PER_PI;

    localparam int POS_W   = 9;
    localparam int CFG_W   = 12;
    localparam int RANGE_W = 12;
    localparam int LEN_W   = RANGE_W + 1;
    localparam int COORD_W = 16;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int PIPE_DEPTH = 5;

    // Offset that keeps mid - position nonnegative; a whole number of turns.
    localparam int WRAP_OFS = TWO_PI_STEPS * ((2 ** POS_W - 1 + TWO_PI_STEPS - 1) / TWO_PI_STEPS);
    localparam int WRAP_MAX = 2 ** POS_W - 1 + WRAP_OFS;
    localparam int WRAP_W   = $clog2(WRAP_MAX + 1);
    localparam int WRAP_SUB = WRAP_MAX / TWO_PI_STEPS;
    localparam int STEP_W   = $clog2(TWO_PI_STEPS);
    localparam int TWICE_W  = STEP_W + 1;
    localparam int REM_W    = (ANGLE_STEPS_PER_PI > 1) ? $clog2(ANGLE_STEPS_PER_PI) : 1;

    localparam int MAG_W  = TRIG_FRAC_BITS + 1;
    localparam int TRIG_W = TRIG_FRAC_BITS + 2;

    localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(longint'(1) << TRIG_FRAC_BITS);

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint SIN_DIV [6] = '{156, 110, 72, 42, 20, 6};
    localparam longint COS_DIV [6] = '{132, 90, 56, 30, 12, 2};

    typedef logic [MAG_W-1:0] t_mag;

    typedef struct packed {
        t_mag sin_mag;
        t_mag cos_mag;
    } t_trig_entry;

    typedef t_trig_entry [ANGLE_STEPS_PER_PI-1:0] t_trig_tab;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quadrant;

    typedef enum logic [1:0] {
        REG_MID_ANGLE    = 2'd0,
        REG_PIVOT_OFFSET = 2'd1,
        REG_SENSOR_ARM   = 2'd2,
        REG_BASE_HEIGHT  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [POS_W-1:0] mid_angle;
        logic [CFG_W-1:0] pivot_offset;
        logic [CFG_W-1:0] sensor_arm;
        logic [CFG_W-1:0] base_height;
    } t_cfg;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] load;
    } t_pipe_ctl;

    // Taylor series in Q30 over the first quadrant, rounded to TRIG_FRAC_BITS.
    function automatic t_trig_tab build_trig_tab();
        t_trig_tab tab;
        longint    r;
        longint    r2;
        longint    hs;
        longint    hc;
        longint    ps;
        longint    pc;
        longint    sv;
        longint    cv;
        longint    half;
        int        k;
        int        j;
        half = longint'(1) << (29 - TRIG_FRAC_BITS);
        for (k = 0; k < ANGLE_STEPS_PER_PI; k++) begin
            r  = (longint'(k) * PI_Q30 + longint'(ANGLE_STEPS_PER_PI))
                 / TWO_PI_STEPS;
            r2 = (r * r) >>> 30;
            hs = Q30_ONE;
            hc = Q30_ONE;
            for (j = 0; j < 6; j++) begin
                ps = (r2 * hs) / Q30_ONE;
                pc = (r2 * hc) / Q30_ONE;
                hs = Q30_ONE - ps / SIN_DIV[j];
                hc = Q30_ONE - pc / COS_DIV[j];
            end
            sv = (r * hs) / Q30_ONE;
            cv = hc;
            if (sv < 0) sv = 0;
            if (sv > Q30_ONE) sv = Q30_ONE;
            if (cv < 0) cv = 0;
            if (cv > Q30_ONE) cv = Q30_ONE;
            tab[k].sin_mag = MAG_W'((sv + half) >>> (30 - TRIG_FRAC_BITS));
            tab[k].cos_mag = MAG_W'((cv + half) >>> (30 - TRIG_FRAC_BITS));
        end
        return tab;
    endfunction

    localparam t_trig_tab TRIG_TAB = build_trig_tab();

endpackage

FILE: rtl/servo_scan_point_to_cartesian_unit.sv
// Top level of the scan point converter: stage control, register port, datapath.
// Depends on ssc_pkg, ssc_apb_regs, ssc_angle_unit and ssc_point_math.
//
//   channel  | valid        | stall        | words
//   ---------+--------------+--------------+-------------------------------------------
//   sample   | i_in_valid   | o_in_stall   | i_pan_position, i_tilt_position, i_range_value
//   point    | o_out_valid  | i_out_stall  | o_coord_x, o_coord_y, o_coord_z
//   config   | psel/penable | pready (= 1) | paddr, pwdata, prdata
//
// One word enters per cycle while o_in_stall is low.
// The datapath has five register stages: angle wrap, table lookup,
// first products, pan projection, scale and clamp.
// Reset clears the stage valid bits and loads the register defaults.
// A stalled output holds its word; bubbles collapse, so upstream stalls only
// when all five stages are full and the output is stalled.
module servo_scan_point_to_cartesian_unit
    import ssc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [POS_W-1:0]          i_pan_position,
    input  logic [POS_W-1:0]          i_tilt_position,
    input  logic [RANGE_W-1:0]        i_range_value,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [COORD_W-1:0] o_coord_x,
    output logic signed [COORD_W-1:0] o_coord_y,
    output logic signed [COORD_W-1:0] o_coord_z,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    t_cfg                     w_cfg;
    t_pipe_ctl                w_ctl;
    logic [PIPE_DEPTH:0]      w_ready;
    logic [PIPE_DEPTH-1:0]    r_vld;
    logic [PIPE_DEPTH-1:0]    n_vld;
    logic signed [TRIG_W-1:0] w_sin1;
    logic signed [TRIG_W-1:0] w_cos1;
    logic signed [TRIG_W-1:0] w_sin2;
    logic signed [TRIG_W-1:0] w_cos2;

    // A stage loads when it is empty or the one after it moves on.
    always_comb begin
        w_ready[PIPE_DEPTH] = !i_out_stall;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
            w_ready[k] = !r_vld[k] || w_ready[k+1];
        end
        w_ctl.load = w_ready[PIPE_DEPTH-1:0];
    end

    always_comb begin
        for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (w_ctl.load[k]) begin
                n_vld[k] = (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_stall  = !w_ready[0];
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    ssc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ssc_angle_unit u_pan (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_mid_angle (w_cfg.mid_angle),
        .i_position  (i_pan_position),
        .o_sin       (w_sin1),
        .o_cos       (w_cos1)
    );

    ssc_angle_unit u_tilt (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_mid_angle (w_cfg.mid_angle),
        .i_position  (i_tilt_position),
        .o_sin       (w_sin2),
        .o_cos       (w_cos2)
    );

    ssc_point_math u_math (
        .i_clk         (i_clk),
        .i_ctl         (w_ctl),
        .i_cfg         (w_cfg),
        .i_range_value (i_range_value),
        .i_sin1        (w_sin1),
        .i_cos1        (w_cos1),
        .i_sin2        (w_sin2),
        .i_cos2        (w_cos2),
        .o_coord_x     (o_coord_x),
        .o_coord_y     (o_coord_y),
        .o_coord_z     (o_coord_z)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ((&r_vld) && i_out_stall))
        else $error("input stalled while the pipeline has room");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[0])
        else $error("accepted sample did not enter the first stage");

    a_pan_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> ((w_sin1 <= TRIG_ONE) && (w_sin1 >= -TRIG_ONE)
                      && (w_cos1 <= TRIG_ONE) && (w_cos1 >= -TRIG_ONE)))
        else $error("pan sine or cosine beyond unity");

    a_tilt_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> ((w_sin2 <= TRIG_ONE) && (w_sin2 >= -TRIG_ONE)
                      && (w_cos2 <= TRIG_ONE) && (w_cos2 >= -TRIG_ONE)))
        else $error("tilt sine or cosine beyond unity");
`endif

endmodule

FILE: rtl/ssc_apb_regs.sv
// APB register file for the scan point converter: angle origin and geometry.
// Depends on ssc_pkg for the register map and the configuration struct.
module ssc_apb_regs
    import ssc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mid_angle    <= POS_W'(90);
            r_cfg.pivot_offset <= '0;
            r_cfg.sensor_arm   <= '0;
            r_cfg.base_height  <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_MID_ANGLE:    r_cfg.mid_angle    <= pwdata[POS_W-1:0];
                REG_PIVOT_OFFSET: r_cfg.pivot_offset <= pwdata[CFG_W-1:0];
                REG_SENSOR_ARM:   r_cfg.sensor_arm   <= pwdata[CFG_W-1:0];
                REG_BASE_HEIGHT:  r_cfg.base_height  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MID_ANGLE:    prdata = PDATA_W'(r_cfg.mid_angle);
            REG_PIVOT_OFFSET: prdata = PDATA_W'(r_cfg.pivot_offset);
            REG_SENSOR_ARM:   prdata = PDATA_W'(r_cfg.sensor_arm);
            REG_BASE_HEIGHT:  prdata = PDATA_W'(r_cfg.base_height);
            default:          prdata = '0;
        endcase
    end

endmodule

FILE: rtl/ssc_angle_unit.sv
// Two pipeline stages that turn a servo position into signed sine and cosine.
// Depends on ssc_pkg for the quadrant table and stage controls.
module ssc_angle_unit
    import ssc_pkg::*;
(
    input  logic                     i_clk,
    input  t_pipe_ctl                i_ctl,
    input  logic [POS_W-1:0]         i_mid_angle,
    input  logic [POS_W-1:0]         i_position,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic signed [TRIG_W-1:0] o_cos
);

    logic [WRAP_W-1:0]  w_wrap;
    logic [WRAP_W-1:0]  w_red;
    logic [STEP_W-1:0]  n_step;
    logic [STEP_W-1:0]  r_step;

    logic [TWICE_W-1:0] w_twice;
    logic [TWICE_W-1:0] w_rem_full;
    logic [REM_W-1:0]   w_rem;
    t_quadrant          w_quad;
    t_trig_entry        w_entry;
    logic signed [TRIG_W-1:0] w_s_pos;
    logic signed [TRIG_W-1:0] w_c_pos;
    logic signed [TRIG_W-1:0] n_sin;
    logic signed [TRIG_W-1:0] n_cos;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [TRIG_W-1:0] r_cos;

    // Stage 1: reduce the step count into one turn.
    assign w_wrap = WRAP_W'(i_mid_angle) + WRAP_W'(WRAP_OFS) - WRAP_W'(i_position);

    always_comb begin
        w_red = w_wrap;
        for (int k = 1; k <= WRAP_SUB; k++) begin
            if (w_wrap >= WRAP_W'(k * TWO_PI_STEPS)) begin
                w_red = w_wrap - WRAP_W'(k * TWO_PI_STEPS);
            end
        end
        n_step = STEP_W'(w_red);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_step <= n_step;
        end
    end

    // Stage 2: split into quadrant and residual, look up, fold signs.
    assign w_twice = {r_step, 1'b0};

    always_comb begin
        w_quad     = QUAD_0;
        w_rem_full = w_twice;
        for (int k = 1; k < 4; k++) begin
            if (w_twice >= TWICE_W'(k * ANGLE_STEPS_PER_PI)) begin
                w_quad     = t_quadrant'(2'(k));
                w_rem_full = w_twice - TWICE_W'(k * ANGLE_STEPS_PER_PI);
            end
        end
        w_rem   = REM_W'(w_rem_full);
        w_entry = TRIG_TAB[w_rem];
        w_s_pos = $signed({1'b0, w_entry.sin_mag});
        w_c_pos = $signed({1'b0, w_entry.cos_mag});
    end

    always_comb begin
        case (w_quad)
            QUAD_0: begin
                n_sin = w_s_pos;
                n_cos = w_c_pos;
            end
            QUAD_1: begin
                n_sin = w_c_pos;
                n_cos = -w_s_pos;
            end
            QUAD_2: begin
                n_sin = -w_s_pos;
                n_cos = -w_c_pos;
            end
            QUAD_3: begin
                n_sin = -w_c_pos;
                n_cos = w_s_pos;
            end
            default: begin
                n_sin = w_s_pos;
                n_cos = w_c_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

FILE: rtl/ssc_point_math.sv
// Length, products, scaling and saturation stages of the scan point converter.
// Depends on ssc_pkg; takes sine and cosine from the two angle units.
module ssc_point_math
    import ssc_pkg::*;
(
    input  logic                      i_clk,
    input  t_pipe_ctl                 i_ctl,
    input  t_cfg                      i_cfg,
    input  logic [RANGE_W-1:0]        i_range_value,
    input  logic signed [TRIG_W-1:0]  i_sin1,
    input  logic signed [TRIG_W-1:0]  i_cos1,
    input  logic signed [TRIG_W-1:0]  i_sin2,
    input  logic signed [TRIG_W-1:0]  i_cos2,
    output logic signed [COORD_W-1:0] o_coord_x,
    output logic signed [COORD_W-1:0] o_coord_y,
    output logic signed [COORD_W-1:0] o_coord_z
);

    localparam int PROD_W = LEN_W + 1 + TRIG_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int XN_W   = ACC_W + TRIG_W;

    localparam logic signed [XN_W-1:0] BIAS_XY =
        XN_W'((longint'(1) << (2 * TRIG_FRAC_BITS)) - 1);
    localparam logic signed [XN_W-1:0] BIAS_Z  =
        XN_W'((longint'(1) << TRIG_FRAC_BITS) - 1);
    localparam logic signed [XN_W-1:0] SAT_HI  = XN_W'(2 ** (COORD_W - 1) - 1);
    localparam logic signed [XN_W-1:0] SAT_LO  = -SAT_HI - XN_W'(1);

    logic [RANGE_W-1:0]       r_range1;
    logic [LEN_W-1:0]         r_len2;

    logic signed [LEN_W:0]    w_len_s;
    logic signed [PROD_W-1:0] w_prod_c2;
    logic signed [PROD_W-1:0] w_prod_s2;
    logic signed [ACC_W-1:0]  w_pivot_q;
    logic signed [ACC_W-1:0]  w_base_q;
    logic signed [ACC_W-1:0]  r_horiz3;
    logic signed [ACC_W-1:0]  r_zn3;
    logic signed [TRIG_W-1:0] r_sin1_3;
    logic signed [TRIG_W-1:0] r_cos1_3;

    logic signed [XN_W-1:0]   r_xn4;
    logic signed [XN_W-1:0]   r_yn4;
    logic signed [ACC_W-1:0]  r_zn4;

    logic signed [XN_W-1:0]   w_zn_ext;
    logic signed [XN_W-1:0]   w_xq;
    logic signed [XN_W-1:0]   w_yq;
    logic signed [XN_W-1:0]   w_zq;
    logic signed [COORD_W-1:0] r_coord_x;
    logic signed [COORD_W-1:0] r_coord_y;
    logic signed [COORD_W-1:0] r_coord_z;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [XN_W-1:0] v
    );
        if (v > SAT_HI) begin
            sat_coord = COORD_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            sat_coord = COORD_W'(SAT_LO);
        end else begin
            sat_coord = COORD_W'(v);
        end
    endfunction

    // Stages 1 and 2: carry the range, then add the arm.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_range1 <= i_range_value;
        end
        if (i_ctl.load[1]) begin
            r_len2 <= LEN_W'(i_cfg.sensor_arm) + LEN_W'(r_range1);
        end
    end

    // Stage 3: horizontal reach and height numerator.
    assign w_len_s   = $signed({1'b0, r_len2});
    assign w_prod_c2 = w_len_s * i_cos2;
    assign w_prod_s2 = w_len_s * i_sin2;
    assign w_pivot_q = $signed(ACC_W'({i_cfg.pivot_offset, {TRIG_FRAC_BITS{1'b0}}}));
    assign w_base_q  = $signed(ACC_W'({i_cfg.base_height, {TRIG_FRAC_BITS{1'b0}}}));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_horiz3 <= w_pivot_q + ACC_W'(w_prod_c2);
            r_zn3    <= w_base_q + ACC_W'(w_prod_s2);
            r_sin1_3 <= i_sin1;
            r_cos1_3 <= i_cos1;
        end
    end

    // Stage 4: project onto the pan angle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_xn4 <= r_horiz3 * r_sin1_3;
            r_yn4 <= r_horiz3 * r_cos1_3;
            r_zn4 <= r_zn3;
        end
    end

    // Stage 5: scale down toward zero, then clamp.
    assign w_zn_ext = XN_W'(r_zn4);
    assign w_xq = (r_xn4 + (r_xn4[XN_W-1] ? BIAS_XY : XN_W'(0))) >>> (2 * TRIG_FRAC_BITS);
    assign w_yq = (r_yn4 + (r_yn4[XN_W-1] ? BIAS_XY : XN_W'(0))) >>> (2 * TRIG_FRAC_BITS);
    assign w_zq = (w_zn_ext + (w_zn_ext[XN_W-1] ? BIAS_Z : XN_W'(0))) >>> TRIG_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r_coord_x <= sat_coord(w_xq);
            r_coord_y <= sat_coord(w_yq);
            r_coord_z <= sat_coord(w_zq);
        end
    end

    assign o_coord_x = r_coord_x;
    assign o_coord_y = r_coord_y;
    assign o_coord_z = r_coord_z;

endmodule
